[design/lbca_pkg.sv]
// Package: widths, codes and controller/datapath interface types of the block chain allocator.
package lbca_pkg;

  // Geometry
  localparam int ID_W   = 10;
  localparam int BLOCKS = 1 << ID_W;
  localparam int CNT_W  = ID_W + 1;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // Stream packing
  localparam int IN_W        = OP_W + CNT_W + 2 * ID_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = ID_W + ST_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [ID_W-1:0]  blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_LINK  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_AWALK,
    S_ASYNC,
    S_AMARK,
    S_FCHK,
    S_FWALK,
    S_FSYNC,
    S_FCLR,
    S_LCHK1,
    S_LCHK2,
    S_DONE
  } state_e;

  // Source of the walk pointer (also the read address of all three stores)
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_NEXT,
    CUR_INC,
    CUR_HEAD,
    CUR_BLK,
    CUR_TGT,
    CUR_FIRST
  } cur_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_ONE,
    CNT_INC
  } cnt_sel_e;

  typedef enum logic [1:0] {
    HEAD_HOLD,
    HEAD_NEXT,
    HEAD_BLK
  } head_sel_e;

  // Store write patterns
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_ALLOC_CUT,
    WR_MARK,
    WR_FREE_CUT,
    WR_UNUSE,
    WR_UNUSE_PUSH,
    WR_LINK
  } wr_e;

  typedef struct packed {
    logic      capture;
    cur_sel_e  cur_sel;
    cnt_sel_e  cnt_sel;
    head_sel_e head_sel;
    logic      first_ld;
    logic      p_ld;
    wr_e       wr;
    logic      res_ld;
    status_e   res_status;
    logic      res_first;
    logic      out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic head_zero;
    logic blk_zero;
    logic tgt_zero;
    logic rd_in_use;
    logic rd_next_zero;
    logic walk_end;
    logic cnt_lt_count;
    logic cnt_at_max;
    logic cur_zero;
    logic cur_last;
    logic p_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

[design/lbca_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module lbca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and read with old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/lbca_dpath.sv]
// Datapath: link and in-use stores, walk pointer, counters, free-list head and result registers.
module lbca_dpath import lbca_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,  // op, count, block, target (from bit 0)
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,  // chain head, status (from bit 0)
  input  ctrl_cmd_t              cmd_i,
  output ctrl_sts_t              sts_o
);

  logic [OP_W-1:0]  op_q;
  cnt_t             count_q;
  blk_t             blk_q;
  blk_t             tgt_q;
  blk_t             cur_q, cur_d;
  cnt_t             cnt_q, cnt_d;
  blk_t             head_q, head_d;
  blk_t             first_q;
  blk_t             p_q;
  status_e          res_status_q;
  blk_t             res_first_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  blk_t       rd_next, rd_prev;
  logic [0:0] rd_use;

  logic       nx_we, pv_we, us_we;
  blk_t       nx_waddr, nx_wdata, pv_waddr, pv_wdata, us_waddr;
  logic [0:0] us_wdata;

  // Walk pointer, step counter and head selection
  always_comb begin
    unique case (cmd_i.cur_sel)
      CUR_HOLD:  cur_d = cur_q;
      CUR_NEXT:  cur_d = rd_next;
      CUR_INC:   cur_d = cur_q + blk_t'(1);
      CUR_HEAD:  cur_d = head_q;
      CUR_BLK:   cur_d = blk_q;
      CUR_TGT:   cur_d = tgt_q;
      CUR_FIRST: cur_d = first_q;
      default:   cur_d = cur_q;
    endcase
    unique case (cmd_i.cnt_sel)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_ZERO: cnt_d = '0;
      CNT_ONE:  cnt_d = cnt_t'(1);
      CNT_INC:  cnt_d = cnt_q + cnt_t'(1);
      default:  cnt_d = cnt_q;
    endcase
    unique case (cmd_i.head_sel)
      HEAD_HOLD: head_d = head_q;
      HEAD_NEXT: head_d = rd_next;
      HEAD_BLK:  head_d = blk_q;
      default:   head_d = head_q;
    endcase
  end

  // Store write ports
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = cur_q;
    nx_wdata = '0;
    pv_we    = 1'b0;
    pv_waddr = cur_q;
    pv_wdata = '0;
    us_we    = 1'b0;
    us_waddr = cur_q;
    us_wdata = 1'b0;
    unique case (cmd_i.wr)
      WR_NONE: ;
      WR_INIT: begin
        nx_we    = 1'b1;
        nx_wdata = cur_q + blk_t'(1);
        pv_we    = 1'b1;
        us_we    = 1'b1;
        us_wdata = (cur_q == '0);
      end
      WR_ALLOC_CUT: begin
        nx_we    = 1'b1;
        pv_we    = (rd_next != '0);
        pv_waddr = rd_next;
      end
      WR_MARK: begin
        us_we    = 1'b1;
        us_wdata = 1'b1;
      end
      WR_FREE_CUT: begin
        nx_we    = 1'b1;
        nx_waddr = p_q;
        pv_we    = 1'b1;
        pv_waddr = blk_q;
      end
      WR_UNUSE: begin
        us_we = 1'b1;
      end
      WR_UNUSE_PUSH: begin
        us_we    = 1'b1;
        nx_we    = 1'b1;
        nx_wdata = head_q;
      end
      WR_LINK: begin
        nx_we    = 1'b1;
        nx_waddr = blk_q;
        nx_wdata = tgt_q;
        pv_we    = 1'b1;
        pv_waddr = tgt_q;
        pv_wdata = blk_q;
      end
      default: ;
    endcase
  end

  lbca_ram #(.WIDTH(ID_W), .DEPTH(BLOCKS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (cur_d),
    .rdata_o (rd_next)
  );

  lbca_ram #(.WIDTH(ID_W), .DEPTH(BLOCKS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .raddr_i (cur_d),
    .rdata_o (rd_prev)
  );

  lbca_ram #(.WIDTH(1), .DEPTH(BLOCKS)) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (us_we),
    .waddr_i (us_waddr),
    .wdata_i (us_wdata),
    .raddr_i (cur_d),
    .rdata_o (rd_use)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cnt_q       <= '0;
      head_q      <= blk_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      cnt_q  <= cnt_d;
      head_q <= head_d;
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= s_tdata_i[OP_W-1:0];
      count_q <= s_tdata_i[OP_W +: CNT_W];
      blk_q   <= s_tdata_i[OP_W+CNT_W +: ID_W];
      tgt_q   <= s_tdata_i[OP_W+CNT_W+ID_W +: ID_W];
    end
    if (cmd_i.first_ld) begin
      first_q <= head_q;
    end
    if (cmd_i.p_ld) begin
      p_q <= rd_prev;
    end
    if (cmd_i.res_ld) begin
      res_status_q <= cmd_i.res_status;
      res_first_q  <= cmd_i.res_first ? first_q : '0;
    end
    if (cmd_i.out_ld) begin
      out_data_q <= {res_status_q, res_first_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_data_q};

  // Status to the controller
  always_comb begin
    sts_o.op           = op_e'(op_q);
    sts_o.count_zero   = (count_q == '0);
    sts_o.head_zero    = (head_q == '0);
    sts_o.blk_zero     = (blk_q == '0);
    sts_o.tgt_zero     = (tgt_q == '0);
    sts_o.rd_in_use    = rd_use[0];
    sts_o.rd_next_zero = (rd_next == '0);
    // the predecessor's link counts as cut while a chain is checked
    sts_o.walk_end     = (rd_next == '0) || ((p_q != '0) && (cur_q == p_q));
    sts_o.cnt_lt_count = (cnt_q < count_q);
    sts_o.cnt_at_max   = (cnt_q == cnt_t'(BLOCKS));
    sts_o.cur_zero     = (cur_q == '0);
    sts_o.cur_last     = (cur_q == blk_t'(BLOCKS - 1));
    sts_o.p_zero       = (p_q == '0);
    sts_o.out_free     = !out_valid_q || m_tready_i;
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(BLOCKS))
    else $error("walk counter beyond store size");

  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before it was taken");

  a_push_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.head_sel == HEAD_BLK) |=> (head_q != '0))
    else $error("free pushed block 0 onto the free list");

endmodule

[design/lbca_ctrl.sv]
// Controller: sequences clearing pass, allocate, free and link walks over the datapath.
module lbca_ctrl import lbca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output ctrl_cmd_t cmd_o,
  input  ctrl_sts_t sts_i
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    s_tready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.cur_sel    = CUR_HOLD;
    cmd_o.cnt_sel    = CNT_HOLD;
    cmd_o.head_sel   = HEAD_HOLD;
    cmd_o.wr         = WR_NONE;
    cmd_o.res_status = ST_OK;
    unique case (state_q)
      // sweep all entries to their reset contents
      S_INIT: begin
        cmd_o.wr      = WR_INIT;
        cmd_o.cur_sel = CUR_INC;
        if (sts_i.cur_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_ALLOC: begin
            if (sts_i.count_zero || sts_i.head_zero) begin
              cmd_o.res_ld     = 1'b1;
              cmd_o.res_status = ST_SHORT;
              state_d          = S_DONE;
            end else begin
              cmd_o.cur_sel  = CUR_HEAD;
              cmd_o.first_ld = 1'b1;
              cmd_o.cnt_sel  = CNT_ONE;
              state_d        = S_AWALK;
            end
          end
          OP_FREE: begin
            if (sts_i.blk_zero) begin
              cmd_o.res_ld     = 1'b1;
              cmd_o.res_status = ST_BAD;
              state_d          = S_DONE;
            end else begin
              cmd_o.cur_sel = CUR_BLK;
              state_d       = S_FCHK;
            end
          end
          OP_LINK: begin
            if (sts_i.blk_zero || sts_i.tgt_zero) begin
              cmd_o.res_ld     = 1'b1;
              cmd_o.res_status = ST_BAD;
              state_d          = S_DONE;
            end else begin
              cmd_o.cur_sel = CUR_BLK;
              state_d       = S_LCHK1;
            end
          end
          default: begin
            cmd_o.res_ld     = 1'b1;
            cmd_o.res_status = ST_BAD;
            state_d          = S_DONE;
          end
        endcase
      end
      // find the last block of the chain to hand out
      S_AWALK: begin
        if (!sts_i.cnt_lt_count) begin
          cmd_o.wr       = WR_ALLOC_CUT;
          cmd_o.head_sel = HEAD_NEXT;
          cmd_o.cur_sel  = CUR_FIRST;
          state_d        = S_ASYNC;
        end else if (sts_i.rd_next_zero) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_SHORT;
          state_d          = S_DONE;
        end else begin
          cmd_o.cur_sel = CUR_NEXT;
          cmd_o.cnt_sel = CNT_INC;
        end
      end
      // re-read the head after the cut
      S_ASYNC: begin
        cmd_o.cnt_sel = CNT_ZERO;
        state_d       = S_AMARK;
      end
      S_AMARK: begin
        if (sts_i.cnt_lt_count && !sts_i.cur_zero) begin
          cmd_o.wr      = WR_MARK;
          cmd_o.cur_sel = CUR_NEXT;
          cmd_o.cnt_sel = CNT_INC;
        end else begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_first  = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_FCHK: begin
        if (!sts_i.rd_in_use) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_BAD;
          state_d          = S_DONE;
        end else begin
          cmd_o.p_ld    = 1'b1;
          cmd_o.cnt_sel = CNT_ZERO;
          state_d       = S_FWALK;
        end
      end
      // check the chain: all in use and no loop
      S_FWALK: begin
        if (!sts_i.rd_in_use || sts_i.cnt_at_max) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_BAD;
          state_d          = S_DONE;
        end else if (sts_i.walk_end) begin
          if (!sts_i.p_zero) begin
            cmd_o.wr = WR_FREE_CUT;
          end
          cmd_o.cur_sel = CUR_BLK;
          state_d       = S_FSYNC;
        end else begin
          cmd_o.cur_sel = CUR_NEXT;
          cmd_o.cnt_sel = CNT_INC;
        end
      end
      S_FSYNC: begin
        state_d = S_FCLR;
      end
      // release each block, then push the chain onto the free list
      S_FCLR: begin
        if (sts_i.rd_next_zero) begin
          cmd_o.wr         = WR_UNUSE_PUSH;
          cmd_o.head_sel   = HEAD_BLK;
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else begin
          cmd_o.wr      = WR_UNUSE;
          cmd_o.cur_sel = CUR_NEXT;
        end
      end
      S_LCHK1: begin
        if (!sts_i.rd_in_use) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_BAD;
          state_d          = S_DONE;
        end else begin
          cmd_o.cur_sel = CUR_TGT;
          state_d       = S_LCHK2;
        end
      end
      S_LCHK2: begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_DONE;
        if (!sts_i.rd_in_use) begin
          cmd_o.res_status = ST_BAD;
        end else begin
          cmd_o.wr         = WR_LINK;
          cmd_o.res_status = ST_OK;
        end
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  a_ready_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_tready_o) |-> ($past(state_q) == S_INIT) || ($past(state_q) == S_DONE))
    else $error("input ready raised outside init or result hand-off");

  a_link_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr == WR_LINK) |-> ($past(state_q) == S_LCHK1))
    else $error("link written without checking the tail block");

endmodule

[design/linked_block_chain_allocator.sv]
// Each input transaction is rejected in decode or runs a link check, an allocate walk
// over n blocks or a free walk over a chain of L blocks (each walk steps one block a cycle).
// One item at a time; the next is taken in the cycle after the result reaches the
// output register, which holds it until the output transaction while the next item runs.
// The walks are bound by the single read port of each link store. After reset (rst_ni low,
// asynchronous) a clearing pass fills all 1024 store entries; s_tready_o stays low till then.
module linked_block_chain_allocator import lbca_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,  // op[1:0], count[12:2], block[22:13], target[32:23]
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o   // chain_head[9:0], status[11:10]
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lbca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lbca_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
